/* sv/lom_pkg.sv */
// lom_pkg: types and constants shared by the order matcher modules
// no dependencies
package lom_pkg;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_CANCEL  = 2'd1;
  localparam logic [1:0] OP_REPLACE = 2'd2;

  localparam logic [2:0] ST_NEW      = 3'd0;
  localparam logic [2:0] ST_PARTIAL  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_CANCELED = 3'd3;
  localparam logic [2:0] ST_REJECTED = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        side;
    logic [31:0] order_id;
    logic [31:0] limit_price;
    logic [31:0] quantity;
  } order_t;

  typedef struct packed {
    logic [31:0] event_order_id;
    logic        event_side;
    logic [2:0]  event_status;
    logic [31:0] event_price;
    logic [31:0] trade_price;
    logic [31:0] filled_qty;
    logic [31:0] remaining_qty;
    logic        last_event;
  } event_t;

  // front classification travels with the order
  typedef struct packed {
    logic   bad_op;
    order_t ord;
  } cmd_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] price;
    logic [31:0] qty;
  } entry_t;

endpackage

/* sv/lom_if.sv */
// lom_if: valid/ready channel interface with a parameterized payload type
// no dependencies; the payload type is given as a parameter
interface lom_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/limit_order_matcher_core.sv */
// limit_order_matcher_core: top level of the price-time priority order matcher
// depends on lom_pkg, lom_if, lom_front, lom_engine
//
// usage
//   in channel (sink): one word per order {opcode, side, order_id, limit_price, quantity}
//   out channel (source): one word per event; last_event marks the final event of an order
//   an order yields 1 to 2*BOOK_DEPTH+2 events
// order flow
//   the front queue holds two orders; the engine works one order at a time and sets the rate
//   an unknown opcode is rejected without the search step; engine steps per order grow
//   with each match and each time a resting order leaves the book; a replace adds its
//   cancel steps; every event word is registered in the output register
// reset
//   rst (synchronous) empties both books, the queue and the output register,
//   and clears the market price
// stalls
//   the engine holds in its emit step while the output register is full and
//   out.ready is low; the front keeps taking orders until its queue fills
module limit_order_matcher_core #(
  parameter int BOOK_DEPTH = 16
) (
  input logic clk,
  input logic rst,
  lom_if.sink   in,
  lom_if.source out
);
  logic          q_valid, q_ready;
  lom_pkg::cmd_t q_data;

  // front: accept and classify
  lom_front u_front (
    .clk, .rst,
    .in_valid (in.valid), .in_ready (in.ready), .in_data (in.data),
    .q_valid, .q_ready, .q_data
  );

  // back: books and matching
  lom_engine #(.BOOK_DEPTH(BOOK_DEPTH)) u_engine (
    .clk, .rst,
    .c_valid (q_valid), .c_ready (q_ready), .c_data (q_data),
    .e_valid (out.valid), .e_ready (out.ready), .e_data (out.data)
  );
endmodule

/* sv/lom_front.sv */
// lom_front: accepts orders, flags unknown opcodes, two-entry queue to the engine
// depends on lom_pkg
module lom_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lom_pkg::order_t    in_data,
  output logic               q_valid,
  input  logic               q_ready,
  output lom_pkg::cmd_t      q_data
);
  lom_pkg::cmd_t slot [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;
  logic          push, pop;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_valid  = (count != 2'd0);
  assign q_data   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr].ord    <= in_data;
      slot[wr_ptr].bad_op <= (in_data.opcode != lom_pkg::OP_ADD) &&
                             (in_data.opcode != lom_pkg::OP_CANCEL) &&
                             (in_data.opcode != lom_pkg::OP_REPLACE);
    end
  end
endmodule

/* sv/lom_engine.sv */
// lom_engine: book state, search, matching and insert sequencer
// depends on lom_pkg
module lom_engine #(
  parameter int BOOK_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            c_valid,
  output logic            c_ready,
  input  lom_pkg::cmd_t   c_data,
  output logic            e_valid,
  input  logic            e_ready,
  output lom_pkg::event_t e_data
);
  localparam int IW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FIND   = 7'b0000010,
    S_MATCH  = 7'b0000100,
    S_FILL2  = 7'b0001000,
    S_REST   = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_REMOVE = 7'b1000000
  } state_t;

  state_t state, after_emit;

  lom_pkg::entry_t book  [2][BOOK_DEPTH];
  logic            vld   [2][BOOK_DEPTH];
  logic [31:0]     market_price;
  lom_pkg::order_t cur;
  logic [31:0]     fill_m;
  logic            matched;

  // output register
  logic            out_valid;
  lom_pkg::event_t out_data;
  assign e_valid = out_valid;
  assign e_data  = out_data;
  logic out_free;
  assign out_free = !out_valid || e_ready;

  assign c_ready = (state == S_IDLE);

  // own side lookup
  logic          hit;
  logic [IW-1:0] hit_idx;
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int i = BOOK_DEPTH - 1; i >= 0; i--) begin
      if (vld[cur.side][i] && book[cur.side][i].id == cur.order_id &&
          book[cur.side][i].price == cur.limit_price) begin
        hit = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  // opposite top and crossing
  logic            opp;
  lom_pkg::entry_t top;
  logic            crosses;
  assign opp = ~cur.side;
  assign top = book[opp][0];
  assign crosses = vld[opp][0] && (cur.quantity != 32'd0) &&
                   (cur.side ? (cur.limit_price <= top.price) :
                               (cur.limit_price >= top.price));

  // insert position on own side
  logic [IW:0] ins_pos;
  always_comb begin
    ins_pos = (IW+1)'(BOOK_DEPTH);
    for (int i = BOOK_DEPTH - 1; i >= 0; i--) begin
      if (!vld[cur.side][i] || (cur.side ? (cur.limit_price < book[cur.side][i].price) :
                                           (cur.limit_price > book[cur.side][i].price)))
        ins_pos = (IW+1)'(i);
    end
  end

  // pending removal
  logic          rm_side;
  logic [IW-1:0] rm_idx;
  lom_pkg::event_t ev;
  logic            ev_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      market_price <= '0;
      ev_pend   <= 1'b0;
      for (int s = 0; s < 2; s++)
        for (int i = 0; i < BOOK_DEPTH; i++) vld[s][i] <= 1'b0;
    end else begin
      if (out_valid && e_ready && state != S_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (c_valid) begin
            cur <= c_data.ord;
            matched <= 1'b0;
            if (c_data.bad_op) begin
              ev <= '{c_data.ord.order_id, c_data.ord.side, lom_pkg::ST_REJECTED,
                      c_data.ord.limit_price, market_price, 32'd0, c_data.ord.quantity, 1'b1};
              state <= S_EMIT;
              after_emit <= S_IDLE;
            end else begin
              state <= S_FIND;
            end
          end
        end
        S_FIND: begin
          if (cur.opcode == lom_pkg::OP_ADD) begin
            if (hit || cur.quantity == 32'd0) begin
              ev <= '{cur.order_id, cur.side, lom_pkg::ST_REJECTED, cur.limit_price,
                      market_price, 32'd0, cur.quantity, 1'b1};
              state <= S_EMIT;
              after_emit <= S_IDLE;
            end else begin
              state <= S_MATCH;
            end
          end else if (!hit) begin
            ev <= '{cur.order_id, cur.side, lom_pkg::ST_REJECTED, cur.limit_price,
                    market_price, 32'd0, cur.quantity, 1'b1};
            state <= S_EMIT;
            after_emit <= S_IDLE;
          end else begin
            ev <= '{book[cur.side][hit_idx].id, cur.side, lom_pkg::ST_CANCELED,
                    book[cur.side][hit_idx].price, market_price, 32'd0,
                    book[cur.side][hit_idx].qty,
                    (cur.opcode == lom_pkg::OP_CANCEL) || (cur.quantity == 32'd0)};
            rm_side <= cur.side;
            rm_idx  <= hit_idx;
            state <= S_EMIT;
            after_emit <= S_REMOVE;
          end
        end
        S_REMOVE: begin
          for (int i = 0; i < BOOK_DEPTH; i++) begin
            if (IW'(i) >= rm_idx) begin
              if (i + 1 < BOOK_DEPTH) begin
                book[rm_side][i] <= book[rm_side][(i + 1) % BOOK_DEPTH];
                vld[rm_side][i]  <= vld[rm_side][(i + 1) % BOOK_DEPTH];
              end else begin
                vld[rm_side][i] <= 1'b0;
              end
            end
          end
          if (ev_pend) begin
            ev_pend <= 1'b0;
            state <= S_MATCH;
          end else if (cur.opcode == lom_pkg::OP_ADD) begin
            state <= S_MATCH;
          end else if (cur.opcode == lom_pkg::OP_CANCEL || cur.quantity == 32'd0) begin
            state <= S_IDLE;
          end else begin
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          if (crosses) begin
            logic [31:0] m;
            logic [31:0] mp;
            m  = (cur.quantity < top.qty) ? cur.quantity : top.qty;
            mp = cur.side ? top.price : cur.limit_price;
            market_price <= mp;
            fill_m <= m;
            matched <= 1'b1;
            ev <= '{top.id, opp, (top.qty == m) ? lom_pkg::ST_FULL : lom_pkg::ST_PARTIAL,
                    top.price, mp, m, top.qty - m, 1'b0};
            book[opp][0].qty <= top.qty - m;
            state <= S_EMIT;
            after_emit <= S_FILL2;
          end else if (cur.quantity != 32'd0) begin
            state <= S_REST;
          end else begin
            state <= S_IDLE;
          end
        end
        S_FILL2: begin
          logic [31:0] left;
          left = cur.quantity - fill_m;
          cur.quantity <= left;
          // fill event for the incoming order; last only when nothing is left
          ev <= '{cur.order_id, cur.side, (left == 32'd0) ? lom_pkg::ST_FULL :
                  lom_pkg::ST_PARTIAL, cur.limit_price, market_price, fill_m, left,
                  (left == 32'd0)};
          if (book[opp][0].qty == 32'd0) begin
            rm_side <= opp;
            rm_idx  <= '0;
            ev_pend <= 1'b1;
            after_emit <= S_REMOVE;
          end else begin
            after_emit <= S_MATCH;
          end
          state <= S_EMIT;
        end
        S_REST: begin
          if (vld[cur.side][BOOK_DEPTH-1]) begin
            ev <= '{cur.order_id, cur.side, lom_pkg::ST_REJECTED, cur.limit_price,
                    market_price, 32'd0, cur.quantity, 1'b1};
          end else begin
            for (int i = BOOK_DEPTH - 1; i >= 0; i--) begin
              if ((IW+1)'(i) > ins_pos) begin
                book[cur.side][i] <= book[cur.side][(i + BOOK_DEPTH - 1) % BOOK_DEPTH];
                vld[cur.side][i]  <= vld[cur.side][(i + BOOK_DEPTH - 1) % BOOK_DEPTH];
              end else if ((IW+1)'(i) == ins_pos) begin
                book[cur.side][i] <= '{cur.order_id, cur.limit_price, cur.quantity};
                vld[cur.side][i]  <= 1'b1;
              end
            end
            ev <= '{cur.order_id, cur.side, matched ? lom_pkg::ST_PARTIAL : lom_pkg::ST_NEW,
                    cur.limit_price, market_price, 32'd0, cur.quantity, 1'b1};
          end
          state <= S_EMIT;
          after_emit <= S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= ev;
            state     <= after_emit;
            if (after_emit == S_REMOVE && !ev.last_event && ev.event_status ==
                lom_pkg::ST_CANCELED) ev_pend <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* sv/lom_checker.sv */
// lom_checker: port-level assertions for the order matcher, bound to the top
// depends on lom_pkg
module lom_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input lom_pkg::event_t out_data
);
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.event_status <= lom_pkg::ST_REJECTED) else $error("bad status");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.filled_qty != 32'd0 |->
    (out_data.event_status == lom_pkg::ST_FULL ||
     out_data.event_status == lom_pkg::ST_PARTIAL)) else $error("fill status");
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_status == lom_pkg::ST_FULL |->
    out_data.remaining_qty == 32'd0) else $error("full not zero");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("hold");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid && in_ready)
    else $error("reset");
endmodule

bind limit_order_matcher_core lom_checker u_chk (
  .clk (clk), .rst (rst),
  .in_ready (in.ready),
  .out_valid (out.valid), .out_ready (out.ready), .out_data (out.data)
);

/* tb/limit_order_matcher_core_tb.sv */
// limit_order_matcher_core_tb: self-checking bench for the order matcher top level
// depends on lom_pkg, lom_if and limit_order_matcher_core
// a directed table, then random order flow, checked against a bench-side book model or a row's typed event
module limit_order_matcher_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  // opcode value the block does not define
  localparam logic [1:0] OP_UNDEF = 2'd3;
  localparam logic SIDE_BUY = 1'b0;
  localparam logic SIDE_SELL = 1'b1;
  localparam int RANDOM_ORDERS = 205;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    bit          valid;
    logic [31:0] id;
    logic [31:0] price;
    logic [31:0] qty;
  } slot_t;

  // one row of the directed table; typed_event is used only when has_typed is set
  typedef struct {
    lom_pkg::order_t ord;
    bit              has_typed;
    lom_pkg::event_t typed_event;
  } row_t;

  logic clk;
  logic rst;

  lom_if #(.payload_t(lom_pkg::order_t)) order_ch (clk);
  lom_if #(.payload_t(lom_pkg::event_t)) event_ch (clk);

  limit_order_matcher_core #(.BOOK_DEPTH(DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .in(order_ch),
    .out(event_ch)
  );

  // bench copy of both books, indexed by side, plus the market price
  slot_t           book [2][DEPTH];
  logic [31:0]     market;
  lom_pkg::event_t pending_events [$];
  int              errors;
  row_t            rows [$];
  int              burst_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  function automatic lom_pkg::event_t make_event(logic [31:0] id, logic side,
                                                 logic [2:0] status, logic [31:0] price,
                                                 logic [31:0] trade, logic [31:0] filled,
                                                 logic [31:0] remain);
    lom_pkg::event_t e;
    e.event_order_id = id;
    e.event_side = side;
    e.event_status = status;
    e.event_price = price;
    e.trade_price = trade;
    e.filled_qty = filled;
    e.remaining_qty = remain;
    e.last_event = 1'b0;
    return e;
  endfunction

  function automatic lom_pkg::order_t make_order(logic [1:0] op, logic side, logic [31:0] id,
                                                 logic [31:0] price, logic [31:0] qty);
    lom_pkg::order_t o;
    o.opcode = op;
    o.side = side;
    o.order_id = id;
    o.limit_price = price;
    o.quantity = qty;
    return o;
  endfunction

  // drop a slot and close the gap so the book stays compacted from index 0
  function automatic void book_remove(int s, int idx);
    for (int i = idx; i + 1 < DEPTH; i++) book[s][i] = book[s][i + 1];
    book[s][DEPTH - 1] = '{1'b0, 32'd0, 32'd0, 32'd0};
  endfunction

  // price/time ordered insert; false when the book is full
  function automatic bit book_insert(int s, logic [31:0] id, logic [31:0] price,
                                     logic [31:0] qty);
    int pos;
    pos = 0;
    if (book[s][DEPTH - 1].valid) return 1'b0;
    while (pos < DEPTH && book[s][pos].valid &&
           !(s ? (price < book[s][pos].price) : (price > book[s][pos].price)))
      pos++;
    for (int i = DEPTH - 1; i > pos; i--) book[s][i] = book[s][i - 1];
    book[s][pos] = '{1'b1, id, price, qty};
    return 1'b1;
  endfunction

  // works out the event words an accepted order causes and updates the books
  function automatic void match_order(lom_pkg::order_t o, output lom_pkg::event_t evs [$]);
    int              own;
    int              opp;
    int              idx;
    logic [31:0]     qty;
    logic [31:0]     m;
    logic [31:0]     left_top;
    logic [2:0]      status;
    lom_pkg::event_t e;
    own = int'(o.side);
    opp = own ^ 1;
    qty = o.quantity;
    status = lom_pkg::ST_NEW;
    idx = -1;
    evs = {};
    if (o.opcode == OP_UNDEF) begin
      evs.push_back(make_event(o.order_id, o.side, lom_pkg::ST_REJECTED, o.limit_price,
                               market, 0, qty));
    end else begin
      for (int i = 0; i < DEPTH; i++)
        if (idx < 0 && book[own][i].valid && book[own][i].id == o.order_id &&
            book[own][i].price == o.limit_price)
          idx = i;
      if (o.opcode == lom_pkg::OP_ADD && (idx >= 0 || qty == 0)) begin
        evs.push_back(make_event(o.order_id, o.side, lom_pkg::ST_REJECTED, o.limit_price,
                                 market, 0, qty));
      end else if (o.opcode != lom_pkg::OP_ADD && idx < 0) begin
        evs.push_back(make_event(o.order_id, o.side, lom_pkg::ST_REJECTED, o.limit_price,
                                 market, 0, qty));
      end else begin
        if (o.opcode != lom_pkg::OP_ADD) begin
          evs.push_back(make_event(book[own][idx].id, o.side, lom_pkg::ST_CANCELED,
                                   book[own][idx].price, market, 0, book[own][idx].qty));
          book_remove(own, idx);
        end
        // cancel, and replace to zero, stop after the canceled word
        if (o.opcode == lom_pkg::OP_ADD || (o.opcode == lom_pkg::OP_REPLACE && qty != 0)) begin
          while (book[opp][0].valid && qty > 0) begin
            if (o.side == SIDE_BUY && o.limit_price < book[opp][0].price) break;
            if (o.side == SIDE_SELL && o.limit_price > book[opp][0].price) break;
            // trade always prints at the buyer's limit
            market = (o.side == SIDE_BUY) ? o.limit_price : book[opp][0].price;
            m = (qty < book[opp][0].qty) ? qty : book[opp][0].qty;
            left_top = book[opp][0].qty - m;
            qty = qty - m;
            status = (qty == 0) ? lom_pkg::ST_FULL : lom_pkg::ST_PARTIAL;
            evs.push_back(make_event(book[opp][0].id, opp[0],
                                     (left_top == 0) ? lom_pkg::ST_FULL : lom_pkg::ST_PARTIAL,
                                     book[opp][0].price, market, m, left_top));
            evs.push_back(make_event(o.order_id, o.side, status, o.limit_price, market, m,
                                     qty));
            if (left_top == 0) book_remove(opp, 0);
            else book[opp][0].qty = left_top;
          end
          if (qty > 0) begin
            if (book_insert(own, o.order_id, o.limit_price, qty))
              evs.push_back(make_event(o.order_id, o.side, status, o.limit_price, market, 0,
                                       qty));
            else
              evs.push_back(make_event(o.order_id, o.side, lom_pkg::ST_REJECTED,
                                       o.limit_price, market, 0, qty));
          end
        end
      end
    end
    e = evs.pop_back();
    e.last_event = 1'b1;
    evs.push_back(e);
  endfunction

  function automatic logic [31:0] rand_price();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom();
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom_range(95, 105);
  endfunction

  function automatic logic [31:0] rand_qty();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'd0;
    if (r == 1) return $urandom();
    return $urandom_range(1, 25);
  endfunction

  // random order; cancels and replaces mostly aim at resting orders
  function automatic lom_pkg::order_t rand_order();
    lom_pkg::order_t o;
    int              r;
    int              live [$];
    int              pick;
    r = $urandom_range(0, 99);
    o.side = 1'($urandom_range(0, 1));
    o.order_id = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 15);
    o.limit_price = rand_price();
    o.quantity = rand_qty();
    if (r < 4) o.opcode = OP_UNDEF;
    else if (r < 62) o.opcode = lom_pkg::OP_ADD;
    else if (r < 81) o.opcode = lom_pkg::OP_CANCEL;
    else o.opcode = lom_pkg::OP_REPLACE;
    if (o.opcode != lom_pkg::OP_ADD && o.opcode != OP_UNDEF && $urandom_range(0, 4) != 0) begin
      for (int i = 0; i < DEPTH; i++) if (book[o.side][i].valid) live.push_back(i);
      if (live.size() > 0) begin
        pick = live[$urandom_range(0, live.size() - 1)];
        o.order_id = book[o.side][pick].id;
        o.limit_price = book[o.side][pick].price;
      end
    end
    return o;
  endfunction

  // present one word and hold it until accepted, then record what it should cause
  task automatic send_order(input lom_pkg::order_t o, input bit has_typed,
                            input lom_pkg::event_t typed);
    lom_pkg::event_t evs [$];
    order_ch.valid <= 1'b1;
    order_ch.data <= o;
    do @(posedge clk); while (!order_ch.ready);
    match_order(o, evs);
    if (has_typed) begin
      typed.last_event = 1'b1;
      evs = {typed};
    end
    foreach (evs[i]) pending_events.push_back(evs[i]);
    // sender idles in bursts: gaps of random length between runs of back-to-back words
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 2) != 0) begin
        order_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // directed table: extremes, every opcode, the named special cases, a full book
  initial begin
    rows.push_back('{make_order(OP_UNDEF, SIDE_BUY, 32'd1, 32'd5, 32'd7), 1'b1,
                     make_event(32'd1, SIDE_BUY, lom_pkg::ST_REJECTED, 32'd5, 32'd0, 32'd0,
                                32'd7)});
    rows.push_back('{make_order(lom_pkg::OP_ADD, SIDE_SELL, 32'd2, 32'd10, 32'd0), 1'b1,
                     make_event(32'd2, SIDE_SELL, lom_pkg::ST_REJECTED, 32'd10, 32'd0, 32'd0,
                                32'd0)});
    rows.push_back('{make_order(lom_pkg::OP_CANCEL, SIDE_BUY, 32'd3, 32'd10, 32'd4), 1'b1,
                     make_event(32'd3, SIDE_BUY, lom_pkg::ST_REJECTED, 32'd10, 32'd0, 32'd0,
                                32'd4)});
    rows.push_back('{make_order(lom_pkg::OP_REPLACE, SIDE_SELL, 32'd4, 32'd11, 32'd9), 1'b1,
                     make_event(32'd4, SIDE_SELL, lom_pkg::ST_REJECTED, 32'd11, 32'd0, 32'd0,
                                32'd9)});
    rows.push_back('{make_order(lom_pkg::OP_ADD, SIDE_BUY, 32'd10, 32'd100, 32'd50), 1'b1,
                     make_event(32'd10, SIDE_BUY, lom_pkg::ST_NEW, 32'd100, 32'd0, 32'd0,
                                32'd50)});
    rows.push_back('{make_order(lom_pkg::OP_ADD, SIDE_BUY, 32'd10, 32'd100, 32'd8), 1'b1,
                     make_event(32'd10, SIDE_BUY, lom_pkg::ST_REJECTED, 32'd100, 32'd0, 32'd0,
                                32'd8)});
    rows.push_back('{make_order(lom_pkg::OP_ADD, SIDE_SELL, 32'd20, 32'd90, 32'd20), 1'b0,
                     '0});
    rows.push_back('{make_order(lom_pkg::OP_ADD, SIDE_SELL, 32'd21, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF), 1'b0, '0});
    rows.push_back('{make_order(lom_pkg::OP_ADD, SIDE_BUY, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'd5), 1'b0, '0});
    rows.push_back('{make_order(lom_pkg::OP_REPLACE, SIDE_BUY, 32'd10, 32'd100, 32'd0), 1'b0,
                     '0});
    rows.push_back('{make_order(lom_pkg::OP_REPLACE, SIDE_SELL, 32'd21, 32'hFFFF_FFFF, 32'd3),
                     1'b0, '0});
    rows.push_back('{make_order(lom_pkg::OP_CANCEL, SIDE_SELL, 32'd21, 32'hFFFF_FFFF, 32'd0),
                     1'b0, '0});
    // fill the bid book, the last add finds it full
    for (int i = 0; i <= DEPTH; i++)
      rows.push_back('{make_order(lom_pkg::OP_ADD, SIDE_BUY, 32'd100 + i, 32'd1 + (i % 4),
                                  32'd2), 1'b0, '0});
    // one sell sweeps the whole bid book, with price 0 and all-ones quantity
    rows.push_back('{make_order(lom_pkg::OP_ADD, SIDE_SELL, 32'd0, 32'd0, 32'hFFFF_FFFF),
                     1'b0, '0});
  end

  // stimulus
  initial begin
    for (int s = 0; s < 2; s++)
      for (int i = 0; i < DEPTH; i++) book[s][i] = '{1'b0, 32'd0, 32'd0, 32'd0};
    market = '0;
    errors = 0;
    burst_left = 0;
    rst <= 1'b1;
    order_ch.valid <= 1'b0;
    order_ch.data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) send_order(rows[i].ord, rows[i].has_typed, rows[i].typed_event);
    for (int n = 0; n < RANDOM_ORDERS; n++) begin
      // once mid-run, hold off until the block has emitted everything
      if (n == RANDOM_ORDERS / 2) begin
        order_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0) @(posedge clk);
      end
      send_order(rand_order(), 1'b0, '0);
    end
    order_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // receiver: stall pattern rotates between none, light and heavy
  int unsigned stall_cycle = 0;

  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    case ((stall_cycle >> 6) % 3)
      0: event_ch.ready <= 1'b1;
      1: event_ch.ready <= ($urandom_range(0, 3) != 0);
      default: event_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // checker: every accepted event word against the oldest expectation
  always @(posedge clk) begin
    lom_pkg::event_t want;
    if (!rst && event_ch.valid && event_ch.ready) begin
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected event word %p", $realtime, event_ch.data);
      end else begin
        want = pending_events.pop_front();
        if (want.event_order_id !== event_ch.data.event_order_id ||
            want.event_side !== event_ch.data.event_side ||
            want.event_status !== event_ch.data.event_status ||
            want.event_price !== event_ch.data.event_price ||
            want.trade_price !== event_ch.data.trade_price ||
            want.filled_qty !== event_ch.data.filled_qty ||
            want.remaining_qty !== event_ch.data.remaining_qty ||
            want.last_event !== event_ch.data.last_event) begin
          errors++;
          $display("%0t: event mismatch expected %p actual %p", $realtime, want,
                   event_ch.data);
        end
      end
    end
  end

endmodule
